/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl of the inverter voltage loop
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/ivlp_pkg.sv */
// types, constants and fixed-point helpers of the inverter voltage loop
// no dependencies; used by the interfaces, the multiplier and the top level
`default_nettype none

package ivlp_pkg;

   localparam int DATA_W         = 32;
   localparam int GAIN_W         = 31;
   localparam int CMP_W          = 16;
   localparam int SUM_W          = 34;
   localparam int PROD_W         = 64;
   localparam int NUM_REGS       = 8;
   localparam int REG_IDX_W      = 3;
   localparam int PWM_PERIOD_DEF = 4096;

   // control register indexes
   typedef enum logic [REG_IDX_W-1:0] {
      REG_PROP_GAIN         = 3'd0,
      REG_INTEG_GAIN        = 3'd1,
      REG_DERIV_GAIN        = 3'd2,
      REG_INTEG_LIMIT       = 3'd3,
      REG_PID_LIMIT         = 3'd4,
      REG_CURRENT_REF_LIMIT = 3'd5,
      REG_INNER_GAIN        = 3'd6,
      REG_DC_LINK_INVERSE   = 3'd7
   } csr_reg_type;

   localparam logic [GAIN_W-1:0] REG_RESET [NUM_REGS] = '{
      31'd6554, 31'd655, 31'd0, 31'd655360,
      31'd655360, 31'd556007, 31'd393216, 31'd1638
   };

   // sequencer steps, one per cycle while a tick runs; idle and out can hold
   typedef enum logic [3:0] {
      ST_IDLE, ST_ERR, ST_DIFF, ST_INTEG, ST_PROP, ST_DERIV, ST_PID, ST_IREF,
      ST_CERR, ST_MUL_IN, ST_VFF, ST_MUL_DC, ST_MOD, ST_MUL_PWM, ST_OUT
   } state_type;

   // request to the shared multiplier
   typedef struct packed {
      logic                en;
      logic [DATA_W-1:0]   a;
      logic [GAIN_W-1:0]   b;
   } mul_req_type;

   // sign extension of a q16.16 word to the sum width
   function automatic logic signed [SUM_W-1:0] ext_sum(input logic signed [DATA_W-1:0] x);
      return {{(SUM_W-DATA_W){x[DATA_W-1]}}, x};
   endfunction

   // saturate a sum to the int32 range
   function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
      if (v > 34'sd2147483647) begin
         return 32'h7fff_ffff;
      end else if (v < -34'sd2147483648) begin
         return 32'h8000_0000;
      end
      return v[DATA_W-1:0];
   endfunction

   // symmetric clamp to +-lim
   function automatic logic signed [DATA_W-1:0] clamp_sym(input logic signed [SUM_W-1:0] v,
                                                        input logic [GAIN_W-1:0] lim);
      logic signed [SUM_W-1:0] l;
      logic signed [SUM_W-1:0] nl;
      l  = $signed({3'b000, lim});
      nl = -l;
      if (v > l) begin
         return l[DATA_W-1:0];
      end else if (v < nl) begin
         return nl[DATA_W-1:0];
      end
      return v[DATA_W-1:0];
   endfunction

   // round half up to q16.16 and saturate
   function automatic logic signed [DATA_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] r;
      r = (p + 64'sd32768) >>> 16;
      if (r > 64'sd2147483647) begin
         return 32'h7fff_ffff;
      end else if (r < -64'sd2147483648) begin
         return 32'h8000_0000;
      end
      return r[DATA_W-1:0];
   endfunction

   // clamp a compare value to 0..period
   function automatic logic [CMP_W-1:0] cmp_sat(input logic signed [PROD_W-1:0] q,
                                               input logic [CMP_W-1:0] period);
      if (q < 0) begin
         return '0;
      end else if (q > $signed({48'd0, period})) begin
         return period;
      end
      return q[CMP_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/ivlp_if.sv */
// valid/ready channel interfaces of the inverter voltage loop
// depends on ivlp_pkg for the field widths
`default_nettype none

interface ivlp_req_if;
   import ivlp_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [DATA_W-1:0]  voltage_target;
   logic signed [DATA_W-1:0]  voltage_measured;
   logic signed [DATA_W-1:0]  current_measured;

   modport source (output valid, voltage_target, voltage_measured, current_measured,
                   input ready);
   modport sink   (input valid, voltage_target, voltage_measured, current_measured,
                   output ready);
endinterface

interface ivlp_rsp_if;
   import ivlp_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [DATA_W-1:0]  modulation_index;
   logic [CMP_W-1:0]          leg_a_compare;
   logic [CMP_W-1:0]          leg_b_compare;
   logic [CMP_W-1:0]          center_compare;

   modport source (output valid, modulation_index, leg_a_compare, leg_b_compare,
                   center_compare, input ready);
   modport sink   (input valid, modulation_index, leg_a_compare, leg_b_compare,
                   center_compare, output ready);
endinterface

`default_nettype wire

/* rtl/core/ivlp_mul.sv */
// shared 32 x 31 signed multiplier with a registered product
// depends on ivlp_pkg for the request struct and widths
`default_nettype none

module ivlp_mul (
   input  wire                                   clock,
   input  ivlp_pkg::mul_req_type                 mul_req,
   output logic signed [ivlp_pkg::PROD_W-1:0]    prod_ff
);
   import ivlp_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   // full product; the gain operand is always non-negative
   assign prod_in = $signed(mul_req.a) * $signed({1'b0, mul_req.b});

   // product holds until the next request
   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/inverter_voltage_loop_pid.sv */
// top level of the cascaded pid voltage/current loop with spwm compares
// depends on ivlp_pkg, ivlp_if, ivlp_mul and assert_macros.svh
//
//  channel | direction | handshake        | payload
//  req_ch  | in        | valid / ready    | voltage_target, voltage_measured, current_measured
//  rsp_ch  | out       | valid / ready    | modulation_index, leg_a/b_compare, center_compare
//  csr_*   | in        | write enable     | csr_index, csr_wdata (31 bits, no read-back)
//
// a tick steps through the sequencer from err to out: six products go through the
// single shared multiplier in turn, with a sum, clamp or rounding step between them.
// the result is held in the output register; ready is high only in idle.
// a waiting result does not block the next tick; a tick that finishes before the previous
// result is taken holds in its last step until the output register frees.
// reset (synchronous) restores the register defaults and clears loop state.
`default_nettype none
`include "assert_macros.svh"

module inverter_voltage_loop_pid #(
   parameter int PWM_PERIOD = ivlp_pkg::PWM_PERIOD_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   ivlp_req_if.sink                           req_ch,
   ivlp_rsp_if.source                         rsp_ch,
   input  wire                                csr_wr_en,
   input  ivlp_pkg::csr_reg_type              csr_index,
   input  wire [ivlp_pkg::GAIN_W-1:0]         csr_wdata
);
   import ivlp_pkg::*;

   localparam logic [CMP_W-1:0]          PERIOD_Q = CMP_W'(PWM_PERIOD);
   localparam logic signed [PROD_W-1:0]  HALF_OFS = PROD_W'(PWM_PERIOD) << 16;

   state_type                 state_ff, state_in;
   logic [GAIN_W-1:0]         reg_ff [NUM_REGS];
   logic signed [DATA_W-1:0]  tgt_ff, vmeas_ff, imeas_ff;
   logic signed [DATA_W-1:0]  e_ff, d_ff, prior_ff, acc_ff, tmp_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [DATA_W-1:0]  prod_q;
   logic                      rsp_valid_ff;
   logic signed [DATA_W-1:0]  out_mod_ff;
   logic [CMP_W-1:0]          out_a_ff, out_b_ff, out_c_ff;
   logic                      req_xfer;
   logic                      out_load;
   mul_req_type               mul_req;
   logic signed [PROD_W-1:0]  neg_prod;
   logic signed [PROD_W-1:0]  ctr_prod;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ch.ready);
   assign prod_q   = round_q16(prod_ff);
   assign neg_prod = -prod_ff;
   assign ctr_prod = prod_ff + HALF_OFS;

   // shared multiplier
   ivlp_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod_ff (prod_ff)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_REGS; k++) begin
            reg_ff[k] <= REG_RESET[k];
         end
      end else if (csr_wr_en) begin
         reg_ff[csr_index] <= csr_wdata;
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next step
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_xfer) state_in = ST_ERR;
         ST_ERR:     state_in = ST_DIFF;
         ST_DIFF:    state_in = ST_INTEG;
         ST_INTEG:   state_in = ST_PROP;
         ST_PROP:    state_in = ST_DERIV;
         ST_DERIV:   state_in = ST_PID;
         ST_PID:     state_in = ST_IREF;
         ST_IREF:    state_in = ST_CERR;
         ST_CERR:    state_in = ST_MUL_IN;
         ST_MUL_IN:  state_in = ST_VFF;
         ST_VFF:     state_in = ST_MUL_DC;
         ST_MUL_DC:  state_in = ST_MOD;
         ST_MOD:     state_in = ST_MUL_PWM;
         ST_MUL_PWM: state_in = ST_OUT;
         ST_OUT:     if (out_load) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // multiplier operand selection and input ready
   always_comb begin
      mul_req      = '0;
      req_ch.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         ST_DIFF: begin
            mul_req = '{en: 1'b1, a: e_ff, b: reg_ff[REG_INTEG_GAIN]};
         end
         ST_INTEG: begin
            mul_req = '{en: 1'b1, a: e_ff, b: reg_ff[REG_PROP_GAIN]};
         end
         ST_PROP: begin
            mul_req = '{en: 1'b1, a: d_ff, b: reg_ff[REG_DERIV_GAIN]};
         end
         ST_MUL_IN: begin
            mul_req = '{en: 1'b1, a: tmp_ff, b: reg_ff[REG_INNER_GAIN]};
         end
         ST_MUL_DC: begin
            mul_req = '{en: 1'b1, a: tmp_ff, b: reg_ff[REG_DC_LINK_INVERSE]};
         end
         ST_MUL_PWM: begin
            mul_req = '{en: 1'b1, a: tmp_ff, b: GAIN_W'(PWM_PERIOD)};
         end
         default: begin
            mul_req = '0;
         end
      endcase
   end

   // loop state, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         prior_ff <= '0;
         acc_ff   <= '0;
      end else begin
         case (state_ff)
            ST_DIFF:  prior_ff <= e_ff;
            ST_INTEG: acc_ff   <= clamp_sym(ext_sum(sat_sum(ext_sum(acc_ff) + ext_sum(prod_q))),
                                            reg_ff[REG_INTEG_LIMIT]);
            default:  acc_ff   <= acc_ff;
         endcase
      end
   end

   // working registers of one tick
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         tgt_ff   <= req_ch.voltage_target;
         vmeas_ff <= req_ch.voltage_measured;
         imeas_ff <= req_ch.current_measured;
      end
      case (state_ff)
         ST_ERR:   e_ff   <= sat_sum(ext_sum(tgt_ff) - ext_sum(vmeas_ff));
         ST_DIFF:  d_ff   <= sat_sum(ext_sum(e_ff) - ext_sum(prior_ff));
         ST_PROP:  sum_ff <= ext_sum(prod_q) + ext_sum(acc_ff);
         ST_DERIV: sum_ff <= sum_ff + ext_sum(prod_q);
         ST_PID:   tmp_ff <= clamp_sym(sum_ff, reg_ff[REG_PID_LIMIT]);
         ST_IREF:  tmp_ff <= clamp_sym(ext_sum(tmp_ff), reg_ff[REG_CURRENT_REF_LIMIT]);
         ST_CERR:  tmp_ff <= sat_sum(ext_sum(tmp_ff) - ext_sum(imeas_ff));
         ST_VFF:   tmp_ff <= sat_sum(ext_sum(prod_q) + ext_sum(vmeas_ff));
         ST_MOD:   tmp_ff <= prod_q;
         default:  tmp_ff <= tmp_ff;
      endcase
   end

   // output register, parts the sequencer from the result channel
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // compare values from modulation times period
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_mod_ff <= tmp_ff;
         out_a_ff   <= cmp_sat(prod_ff >>> 16, PERIOD_Q);
         out_b_ff   <= cmp_sat(neg_prod >>> 16, PERIOD_Q);
         out_c_ff   <= cmp_sat(ctr_prod >>> 17, PERIOD_Q);
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.modulation_index = out_mod_ff;
   assign rsp_ch.leg_a_compare    = out_a_ff;
   assign rsp_ch.leg_b_compare    = out_b_ff;
   assign rsp_ch.center_compare   = out_c_ff;

   // checks
   `ASSERT_NEXT(a_start, clock, reset, req_xfer, state_ff == ST_ERR)
   `ASSERT_NEXT(a_hold, clock, reset, state_ff == ST_OUT && rsp_valid_ff && !rsp_ch.ready, state_ff == ST_OUT)
   `ASSERT_IMPL(a_range, clock, reset, rsp_valid_ff, out_a_ff <= PERIOD_Q && out_b_ff <= PERIOD_Q && out_c_ff <= PERIOD_Q)
   `ASSERT_IMPL(a_legs, clock, reset, rsp_valid_ff, out_a_ff == '0 || out_b_ff == '0)

endmodule

`default_nettype wire

/* tb/inverter_voltage_loop_pid_tb.sv */
// self-checking testbench of the cascaded pid voltage/current loop with spwm compares
// depends on ivlp_pkg and ivlp_if from the rtl, and on the inverter_voltage_loop_pid top level
`timescale 1ns / 1ps

module inverter_voltage_loop_pid_tb;
   import ivlp_pkg::*;

   localparam longint PERIOD      = PWM_PERIOD_DEF;
   localparam int     STALL_LIMIT = 2000;
   localparam int     SETTLE      = 20;
   localparam int     TAIL        = 40;

   localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] V40      = 32'sd2621440;
   localparam logic signed [DATA_W-1:0] V311     = 32'sd20381696;
   localparam logic signed [DATA_W-1:0] A10      = 32'sd655360;
   localparam logic signed [DATA_W-1:0] ALT_A    = 32'sh5555_5555;
   localparam logic signed [DATA_W-1:0] ALT_B    = 32'shaaaa_aaaa;

   typedef struct packed {
      logic signed [DATA_W-1:0] voltage_target;
      logic signed [DATA_W-1:0] voltage_measured;
      logic signed [DATA_W-1:0] current_measured;
   } tick_in_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] modulation_index;
      logic [CMP_W-1:0]         leg_a_compare;
      logic [CMP_W-1:0]         leg_b_compare;
      logic [CMP_W-1:0]         center_compare;
   } pwm_result_type;

   typedef logic [GAIN_W-1:0] reg_set_type [NUM_REGS];

   // loop predictor and store of expected pwm results
   class pwm_scoreboard;
      longint         gain [NUM_REGS];
      int             prior_error;
      int             integ_accum;
      pwm_result_type expected_pwm [$];
      int             mismatches;
      int             checked;

      function new();
         gain        = '{6554, 655, 0, 655360, 655360, 556007, 393216, 1638};
         prior_error = 0;
         integ_accum = 0;
         mismatches  = 0;
         checked     = 0;
      endfunction

      function void set_gain(csr_reg_type idx, logic [GAIN_W-1:0] v);
         gain[idx] = longint'({33'd0, v});
      endfunction

      function int saturate_word(longint v);
         if (v > longint'(WORD_MAX)) return WORD_MAX;
         if (v < longint'(WORD_MIN)) return WORD_MIN;
         return int'(v);
      endfunction

      // q16.16 product, round half up, saturate
      function int fixed_mul(int a, longint b);
         longint p;
         p = longint'(a) * b + 64'sd32768;
         return saturate_word(p >>> 16);
      endfunction

      function int limit_sym(longint v, longint lim);
         if (v > lim) return int'(lim);
         if (v < -lim) return int'(-lim);
         return int'(v);
      endfunction

      function logic [CMP_W-1:0] to_compare(longint v);
         if (v < 0) return '0;
         if (v > PERIOD) return CMP_W'(PERIOD);
         return CMP_W'(v);
      endfunction

      // one control tick: outer pid, inner current loop, modulation and compares
      function void note_tick(tick_in_type t);
         int             e;
         int             d;
         int             pid;
         int             iref;
         int             cerr;
         int             m;
         longint         vsum;
         longint         mp;
         longint         ctr;
         pwm_result_type r;
         e = saturate_word(longint'(t.voltage_target) - longint'(t.voltage_measured));
         d = saturate_word(longint'(e) - longint'(prior_error));
         integ_accum = saturate_word(longint'(integ_accum)
                                     + longint'(fixed_mul(e, gain[REG_INTEG_GAIN])));
         integ_accum = limit_sym(integ_accum, gain[REG_INTEG_LIMIT]);
         pid = limit_sym(longint'(fixed_mul(e, gain[REG_PROP_GAIN]))
                         + longint'(fixed_mul(d, gain[REG_DERIV_GAIN]))
                         + longint'(integ_accum), gain[REG_PID_LIMIT]);
         iref = limit_sym(pid, gain[REG_CURRENT_REF_LIMIT]);
         cerr = saturate_word(longint'(iref) - longint'(t.current_measured));
         vsum = longint'(fixed_mul(cerr, gain[REG_INNER_GAIN])) + longint'(t.voltage_measured);
         m = fixed_mul(saturate_word(vsum), gain[REG_DC_LINK_INVERSE]);
         prior_error = e;
         // compares saturate instead of wrapping
         mp  = longint'(m) * PERIOD;
         ctr = mp + PERIOD * 65536;
         r.modulation_index = m;
         r.leg_a_compare    = (mp < 0) ? '0 : to_compare(mp / 65536);
         r.leg_b_compare    = (mp > 0) ? '0 : to_compare((-mp) / 65536);
         r.center_compare   = (ctr < 0) ? '0 : to_compare(ctr / 131072);
         expected_pwm.push_back(r);
      endfunction

      task report_mismatch(string msg);
         if (mismatches < 200) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
         end
         mismatches++;
      endtask

      task compare_field(string name, longint got, longint want);
         if (got != want) begin
            report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                      checked, name, got, want));
         end
      endtask

      task check_pwm(pwm_result_type got);
         pwm_result_type want;
         if (expected_pwm.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, modulation_index %0d",
                                      got.modulation_index));
            return;
         end
         want = expected_pwm.pop_front();
         checked++;
         compare_field("modulation_index", got.modulation_index, want.modulation_index);
         compare_field("leg_a_compare", got.leg_a_compare, want.leg_a_compare);
         compare_field("leg_b_compare", got.leg_b_compare, want.leg_b_compare);
         compare_field("center_compare", got.center_compare, want.center_compare);
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   csr_reg_type         csr_index;
   logic [GAIN_W-1:0]   csr_wdata;

   ivlp_req_if req_ch ();
   ivlp_rsp_if rsp_ch ();

   pwm_scoreboard sb;
   int            snd_idle_pct;
   int            rcv_idle_pct;
   int            stall_cycles;
   int            ticks_in;
   int            settings_count;

   inverter_voltage_loop_pid #(
      .PWM_PERIOD (PWM_PERIOD_DEF)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // monitor: transfers on both channels and the no-progress counter
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_tick(tick_in_type'{req_ch.voltage_target, req_ch.voltage_measured,
                                       req_ch.current_measured});
            ticks_in++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_pwm(pwm_result_type'{rsp_ch.modulation_index, rsp_ch.leg_a_compare,
                                          rsp_ch.leg_b_compare, rsp_ch.center_compare});
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   // watchdog
   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("no transfer for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   // one tick on the request channel, with random gaps before it
   task send_tick(tick_in_type t);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.voltage_target   <= t.voltage_target;
      req_ch.voltage_measured <= t.voltage_measured;
      req_ch.current_measured <= t.current_measured;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
   endtask

   // hold the sender until every expected result is in
   task drain_ticks(int extra);
      req_ch.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (sb.expected_pwm.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task program_regs(reg_set_type vals);
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= csr_reg_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.set_gain(csr_reg_type'(i), vals[i]);
      end
      csr_wr_en <= 1'b0;
      settings_count++;
   endtask

   // gains and limits in a range where the loop mostly stays out of saturation
   function automatic reg_set_type moderate_regs();
      reg_set_type r;
      r[REG_PROP_GAIN]         = GAIN_W'($urandom_range(0, 1 << 18));
      r[REG_INTEG_GAIN]        = GAIN_W'($urandom_range(0, 1 << 14));
      r[REG_DERIV_GAIN]        = GAIN_W'($urandom_range(0, 1 << 16));
      r[REG_INTEG_LIMIT]       = GAIN_W'($urandom_range(0, 1 << 24));
      r[REG_PID_LIMIT]         = GAIN_W'($urandom_range(0, 1 << 24));
      r[REG_CURRENT_REF_LIMIT] = GAIN_W'($urandom_range(0, 1 << 24));
      r[REG_INNER_GAIN]        = GAIN_W'($urandom_range(0, 1 << 20));
      r[REG_DC_LINK_INVERSE]   = GAIN_W'($urandom_range(0, 1 << 13));
      return r;
   endfunction

   function automatic reg_set_type wild_regs();
      reg_set_type r;
      for (int i = 0; i < NUM_REGS; i++) begin
         r[i] = GAIN_W'($urandom());
      end
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] extreme_word();
      case ($urandom_range(0, 4))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3: return -32'sd1;
         default: return 32'sd1;
      endcase
   endfunction

   // mostly plausible grid samples, then raw words and corner values
   function automatic tick_in_type random_tick();
      tick_in_type t;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         t.voltage_target   = $signed($urandom_range(0, 800 * 65536)) - 400 * 65536;
         t.voltage_measured = t.voltage_target
                              + ($signed($urandom_range(0, 40 * 65536)) - 20 * 65536);
         t.current_measured = $signed($urandom_range(0, 60 * 65536)) - 30 * 65536;
      end else if (pick < 90) begin
         t.voltage_target   = $urandom();
         t.voltage_measured = $urandom();
         t.current_measured = $urandom();
      end else begin
         t.voltage_target   = extreme_word();
         t.voltage_measured = extreme_word();
         t.current_measured = extreme_word();
      end
      return t;
   endfunction

   task run_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 59) == 0) begin
            drain_ticks(0);
         end
         send_tick(random_tick());
      end
   endtask

   tick_in_type directed_ticks [20];

   // stimulus sequence
   initial begin
      sb                      = new();
      settings_count          = 0;
      reset                   <= 1'b1;
      req_ch.valid            <= 1'b0;
      req_ch.voltage_target   <= '0;
      req_ch.voltage_measured <= '0;
      req_ch.current_measured <= '0;
      csr_wr_en               <= 1'b0;
      csr_index               <= REG_PROP_GAIN;
      csr_wdata               <= '0;
      snd_idle_pct            = 27;
      rcv_idle_pct            = 58;

      // zero, error and derivative overflow both ways, full-scale inputs, alternating patterns
      directed_ticks = '{
         '{32'sd0, 32'sd0, 32'sd0},
         '{WORD_MAX, WORD_MIN, 32'sd0},
         '{WORD_MIN, WORD_MAX, 32'sd0},
         '{WORD_MAX, WORD_MIN, 32'sd0},
         '{32'sd0, WORD_MAX, WORD_MAX},
         '{32'sd0, WORD_MIN, WORD_MIN},
         '{32'sd0, 32'sd0, WORD_MAX},
         '{32'sd0, 32'sd0, WORD_MIN},
         '{WORD_MAX, WORD_MAX, 32'sd0},
         '{WORD_MIN, WORD_MIN, -32'sd1},
         '{V40, V40, 32'sd0},
         '{-V40, -V40, 32'sd0},
         '{V311, V40, A10},
         '{-V311, -V40, -A10},
         '{32'sd1, 32'sd0, 32'sd0},
         '{-32'sd1, 32'sd0, 32'sd0},
         '{-32'sd1, -32'sd1, -32'sd1},
         '{ALT_A, ALT_B, ALT_A},
         '{ALT_B, ALT_A, ALT_B},
         '{32'sd0, 32'sd0, 32'sd0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults after reset
      foreach (directed_ticks[i]) begin
         send_tick(directed_ticks[i]);
      end
      drain_ticks(SETTLE);

      program_regs(moderate_regs());
      run_random(150);
      drain_ticks(SETTLE);

      // every register at its top value
      program_regs('{default: '1});
      run_random(60);
      drain_ticks(SETTLE);

      snd_idle_pct = 58;
      rcv_idle_pct = 27;

      // every register zero, so each limit forces its stage to zero
      program_regs('{default: '0});
      run_random(40);
      drain_ticks(SETTLE);

      program_regs(moderate_regs());
      run_random(150);
      drain_ticks(SETTLE);

      snd_idle_pct = 0;
      rcv_idle_pct = 0;

      program_regs(wild_regs());
      run_random(80);
      drain_ticks(SETTLE);

      program_regs(moderate_regs());
      run_random(150);
      drain_ticks(TAIL);

      $display("%0d ticks driven under reset defaults and %0d written register sets",
               ticks_in, settings_count);
      $display("%0d results compared, sender and receiver stalls swapped then removed",
               sb.checked);
      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
